/* sv/ilir_pkg.sv */
package ilir_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int WORD_BITS_DEFAULT = 32;

  // Fixed widths of the request and result fields
  localparam int CMD_BITS    = 3;
  localparam int POS_BITS    = 5;
  localparam int WORD_IO_BITS = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_READ       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_APPEND     = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_REMOVE     = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_OPEN,
    EDIT_CLOSE
  } edit_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]     command;
    logic [POS_BITS-1:0]     position;
    logic [WORD_IO_BITS-1:0] word_in;
  } request_t;

  typedef struct packed {
    logic [WORD_IO_BITS-1:0] word_out;
    logic [STATUS_BITS-1:0]  status;
    logic [COUNT_BITS-1:0]   entry_count;
  } result_t;

endpackage

/* sv/indexed_list_insert_remove_unit.sv */
// Indexed list with insert and remove at any position, fixed capacity DEPTH.
// Each request passes through a request register and then a result register.
// Throughput: one request per cycle while the consumer does not stall; each command is
// decoded and applied to the entry array between the request and result registers.
// Reset clears the entry count and both register valids; entry contents are undefined.
module indexed_list_insert_remove_unit import ilir_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  request_t cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output result_t  res
);

  // Request register: holds the command while the list works on it
  logic     req_held;
  logic     req_stall;
  request_t req;

  // Result of the held request, straight from the list decode
  result_t  res_next;
  logic     res_in_stall;

  // Apply the held request to the list only when its result can be stored
  logic     go;

  assign go = req_held && !res_in_stall;

  ilir_pipe_reg #(
    .payload_t (request_t)
  ) u_req_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (cmd_valid),
    .up_stall   (cmd_stall),
    .up_data    (cmd),
    .down_valid (req_held),
    .down_stall (req_stall),
    .down_data  (req)
  );

  // Hold the request while the result register is blocked
  assign req_stall = res_in_stall;

  ilir_list #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_list (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .req (req),
    .res (res_next)
  );

  // Result register: parts the list from a stalled consumer
  ilir_pipe_reg #(
    .payload_t (result_t)
  ) u_res_reg (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (req_held),
    .up_stall   (res_in_stall),
    .up_data    (res_next),
    .down_valid (res_valid),
    .down_stall (res_stall),
    .down_data  (res)
  );

endmodule

/* sv/ilir_pipe_reg.sv */
// Valid/stall pipeline register: load when empty or when the held payload leaves.
module ilir_pipe_reg import ilir_pkg::*; #(
  parameter type payload_t = request_t
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  payload_t up_data,
  output logic     down_valid,
  input  logic     down_stall,
  output payload_t down_data
);

  logic     held;
  payload_t data;

  assign up_stall   = held && down_stall;
  assign down_valid = held;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!up_stall) begin
      held <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= up_data;
    end
  end

endmodule

/* sv/ilir_list.sv */
// List storage with per-entry shift muxes, count register and command decode.
module ilir_list import ilir_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  request_t req,
  output result_t  res
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = (CW > POS_BITS) ? CW : POS_BITS;
  localparam int KEEP = (WORD_BITS < WORD_IO_BITS) ? WORD_BITS : WORD_IO_BITS;

  logic [WORD_BITS-1:0] entries [DEPTH];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic [PW-1:0]        cnt_new_w;
  logic [CW-1:0]        cnt_m1;
  logic [IW-1:0]        pos_idx;
  logic                 full;
  logic                 empty;

  edit_t                edit;
  status_t              status;
  logic [IW-1:0]        at;
  logic                 take;
  logic [WORD_BITS-1:0] word_w;
  logic [WORD_BITS-1:0] rd_word;

  assign pos_w   = PW'(req.position);
  assign cnt_w   = PW'(count);
  assign cnt_m1  = count - CW'(1);
  assign pos_idx = pos_w[IW-1:0];
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_word = entries[at];

  always_comb begin
    word_w          = '0;
    word_w[KEEP-1:0] = req.word_in[KEEP-1:0];
  end

  always_comb begin
    status = ST_OK;
    edit   = EDIT_NONE;
    at     = '0;
    take   = 1'b0;
    case (req.command)
      CMD_READ: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          at   = pos_idx;
          take = 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          edit = EDIT_OPEN;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          edit = EDIT_OPEN;
          at   = count[IW-1:0];
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          edit = EDIT_OPEN;
          at   = pos_idx;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          edit = EDIT_CLOSE;
          take = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          edit = EDIT_CLOSE;
          at   = cnt_m1[IW-1:0];
          take = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          edit = EDIT_CLOSE;
          at   = pos_idx;
          take = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (edit)
      EDIT_OPEN:  count_next = count + CW'(1);
      EDIT_CLOSE: count_next = cnt_m1;
      default:    count_next = count;
    endcase
  end

  assign cnt_new_w = PW'(count_next);

  always_comb begin
    res             = '0;
    res.status      = status;
    res.entry_count = cnt_new_w[COUNT_BITS-1:0];
    if (take) begin
      res.word_out[KEEP-1:0] = rd_word[KEEP-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (go) begin
      count <= count_next;
    end
  end

  // Each entry takes the new word, its lower neighbour or its upper neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam int PREV = (i > 0) ? i - 1 : 0;
    localparam int NEXT = (i < DEPTH - 1) ? i + 1 : i;

    always_ff @(posedge clk) begin
      if (go) begin
        case (edit)
          EDIT_OPEN: begin
            if (at == IW'(i)) begin
              entries[i] <= word_w;
            end else if ((i > 0) && (at < IW'(i))) begin
              entries[i] <= entries[PREV];
            end
          end
          EDIT_CLOSE: begin
            if ((i < DEPTH - 1) && (at <= IW'(i))) begin
              entries[i] <= entries[NEXT];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* tb/tb_indexed_list_insert_remove_unit.sv */
module tb_indexed_list_insert_remove_unit import ilir_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 7 has no enum member; the block must treat it as a no-op
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int RANDOM_COUNT = 420;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 2000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  request_t cmd = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  result_t  res;

  indexed_list_insert_remove_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #2 clk = ~clk;

  // Shadow copy of the list, updated as each request is accepted
  logic [WORD_IO_BITS-1:0] list_words [LIST_DEPTH];
  int                      list_held = 0;
  result_t                 list_results_due [$];

  int mismatch_count = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int full_hits      = 0;
  int empty_hits     = 0;
  int range_hits     = 0;
  int burst_left     = 0;
  int cycle_count    = 0;
  int stall_mode     = 0;
  int stall_left     = 0;
  result_t want_result;

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Shift entries at and above the slot up by one, then drop the word in
  function automatic void open_slot(int at, logic [WORD_IO_BITS-1:0] word);
    for (int i = list_held; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = word;
    list_held++;
  endfunction

  // Take the word out of the slot and close the gap behind it
  function automatic logic [WORD_IO_BITS-1:0] close_slot(int at);
    logic [WORD_IO_BITS-1:0] word;
    word = list_words[at];
    for (int i = at; i + 1 < list_held; i++) list_words[i] = list_words[i+1];
    list_held--;
    return word;
  endfunction

  function automatic result_t apply_list_command(request_t req);
    result_t outcome;
    int      at;
    outcome = '0;
    at = req.position;
    case (req.command)
      CMD_READ: begin
        if (at >= list_held) outcome.status = ST_RANGE;
        else outcome.word_out = list_words[at];
      end
      CMD_PUSH_FRONT, CMD_APPEND, CMD_INSERT: begin
        // Full wins over a bad insert position
        if (list_held >= LIST_DEPTH) outcome.status = ST_FULL;
        else if (req.command == CMD_PUSH_FRONT) open_slot(0, req.word_in);
        else if (req.command == CMD_APPEND) open_slot(list_held, req.word_in);
        else if (at > list_held) outcome.status = ST_RANGE;
        else open_slot(at, req.word_in);
      end
      CMD_POP_FRONT: begin
        if (list_held == 0) outcome.status = ST_EMPTY;
        else outcome.word_out = close_slot(0);
      end
      CMD_POP_BACK: begin
        if (list_held == 0) outcome.status = ST_EMPTY;
        else outcome.word_out = close_slot(list_held - 1);
      end
      CMD_REMOVE: begin
        if (list_held == 0) outcome.status = ST_EMPTY;
        else if (at >= list_held) outcome.status = ST_RANGE;
        else outcome.word_out = close_slot(at);
      end
      default: begin
      end
    endcase
    outcome.entry_count = COUNT_BITS'(list_held);
    if (outcome.status == ST_FULL) full_hits++;
    if (outcome.status == ST_EMPTY) empty_hits++;
    if (outcome.status == ST_RANGE) range_hits++;
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic request_t make_request(logic [CMD_BITS-1:0] op, logic [POS_BITS-1:0] at,
                                            logic [WORD_IO_BITS-1:0] word);
    request_t req;
    req.command  = op;
    req.position = at;
    req.word_in  = word;
    return req;
  endfunction

  // Bias towards the all-zero and all-one words so every data bit toggles
  function automatic logic [WORD_IO_BITS-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // Present one request, hold it until accepted, then predict its result.
  // Between bursts drop valid for a random gap; a back-to-back request keeps
  // valid high, so valid never gets two assignments in one step.
  task automatic send_request(request_t req);
    cmd       <= req;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    list_results_due.push_back(apply_list_command(req));
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall in phases - none, light, heavy - each of random length
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 99) < 30);
      default: res_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (list_results_due.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_result = list_results_due.pop_front();
        if (res.word_out !== want_result.word_out)
          report_mismatch($sformatf("word_out %h, want %h", res.word_out,
                                    want_result.word_out));
        if (res.status !== want_result.status)
          report_mismatch($sformatf("status %0d, want %0d", res.status, want_result.status));
        if (res.entry_count !== want_result.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", res.entry_count,
                                    want_result.entry_count));
      end
    end
  end

  // Watchdog: abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("indexed_list_insert_remove_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read, both pops and remove against an empty list, plus the unused code
  task automatic test_empty_list();
    send_request(make_request(CMD_READ, 5'd0, '0));
    send_request(make_request(CMD_POP_FRONT, 5'd0, '1));
    send_request(make_request(CMD_POP_BACK, 5'd31, '0));
    send_request(make_request(CMD_REMOVE, 5'd0, '0));
    send_request(make_request(CMD_UNUSED, 5'd31, '1));
    // Insert beyond the end: flagged, nothing stored
    send_request(make_request(CMD_INSERT, 5'd1, 32'hdead_beef));
  endtask

  // Grow to capacity through every insert flavour, then knock on a full list
  task automatic test_fill_to_full();
    logic [WORD_IO_BITS-1:0] word;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      word = (k == 0) ? '0 : (k == 1) ? '1 : $urandom;
      case (k % 4)
        0: send_request(make_request(CMD_PUSH_FRONT, 5'd31, word));
        1: send_request(make_request(CMD_APPEND, 5'd0, word));
        2: send_request(make_request(CMD_INSERT, POS_BITS'(list_held / 2), word));
        default: send_request(make_request(CMD_INSERT, POS_BITS'(list_held), word));
      endcase
    end
    send_request(make_request(CMD_PUSH_FRONT, 5'd0, '1));
    send_request(make_request(CMD_APPEND, 5'd0, '1));
    // Full is reported ahead of the bad position
    send_request(make_request(CMD_INSERT, 5'd31, '1));
  endtask

  // Index checks at and past the last entry of a full list
  task automatic test_out_of_range();
    send_request(make_request(CMD_READ, 5'd16, '0));
    send_request(make_request(CMD_READ, 5'd31, '0));
    send_request(make_request(CMD_REMOVE, 5'd31, '0));
    send_request(make_request(CMD_REMOVE, 5'd15, '0));
    send_request(make_request(CMD_INSERT, 5'd16, 32'h1234_5678));
    send_request(make_request(CMD_POP_FRONT, 5'd0, '0));
  endtask

  // Alternate growing and shrinking phases so the list keeps hitting both
  // full and empty; mostly sensible indexes, with some raw noise mixed in
  task automatic test_random_grow_shrink(int n_requests);
    int                  roll;
    int                  phase_left;
    bit                  growing;
    bit                  insert_side;
    logic [CMD_BITS-1:0] op;
    logic [POS_BITS-1:0] at;
    phase_left = 0;
    growing    = 1'b0;
    repeat (n_requests) begin
      if (phase_left == 0) begin
        growing    = !growing;
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      at   = POS_BITS'($urandom_range(0, 31));
      insert_side = growing ? (roll < 75) : (roll < 42);
      if (roll < 5) begin
        op = CMD_BITS'($urandom_range(0, 7));
      end else if (roll < 20) begin
        op = CMD_READ;
        if (list_held > 0 && roll < 17) at = POS_BITS'($urandom_range(0, list_held - 1));
      end else if (insert_side) begin
        case ($urandom_range(0, 2))
          0: op = CMD_PUSH_FRONT;
          1: op = CMD_APPEND;
          default: op = CMD_INSERT;
        endcase
        if (op == CMD_INSERT && roll % 10 != 0) at = POS_BITS'($urandom_range(0, list_held));
      end else begin
        case ($urandom_range(0, 2))
          0: op = CMD_POP_FRONT;
          1: op = CMD_POP_BACK;
          default: op = CMD_REMOVE;
        endcase
        if (op == CMD_REMOVE && list_held > 0 && roll % 10 != 0)
          at = POS_BITS'($urandom_range(0, list_held - 1));
      end
      send_request(make_request(op, at, pick_word()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain_cycles;
    drain_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_fill_to_full();
    test_out_of_range();
    test_random_grow_shrink(RANDOM_COUNT);

    // Stop sending, wait for outstanding results, then let the pipe settle
    cmd_valid <= 1'b0;
    while (list_results_due.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (list_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", list_results_due.size()));
    repeat (6) @(posedge clk);

    $display("Sent %0d list requests and checked %0d results.", requests_sent, results_seen);
    $display("Refusals seen: %0d full, %0d empty, %0d out of range; %0d mismatches.",
             full_hits, empty_hits, range_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("indexed_list_insert_remove_unit test passed");
    end else begin
      $display("indexed_list_insert_remove_unit test failed");
    end
    $finish;
  end

endmodule
